FILE: design/pcx_rle_palette_decoder_top_assert.svh
// Assertion macros shared by the PCX run-length decoder modules.
`ifndef PCX_RLE_PALETTE_DECODER_TOP_ASSERT_SVH
`define PCX_RLE_PALETTE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication checked on every clock edge outside reset.
`define PCX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcx_rle: same-cycle check failed");

// Next-cycle implication checked on every clock edge outside reset.
`define PCX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcx_rle: next-cycle check failed");

`endif

FILE: design/pcx_rle_pkg.sv
// Shared types and constants of the PCX run-length palette decoder.
package pcx_rle_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int RGB_W       = 24;
  localparam int RUN_W       = 6;
  localparam int LW_W        = 10;

  localparam logic [7:0]      RUN_MARK     = 8'hC0;
  localparam logic [7:0]      RUN_LEN_MASK = 8'h3F;
  localparam logic [LW_W-1:0] LW_RESET     = 10'd320;

  localparam logic [0:0] REQ_PALETTE = 1'b0;
  localparam logic [0:0] REQ_DATA    = 1'b1;

  localparam int REG_LINE_WIDTH = 0;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  typedef struct packed {
    logic pal_wr;
    logic set_pend;
    logic start;
    logic start_run;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hdr;
    logic pend;
    logic pend_zero;
    logic last_pix;
    logic load_ok;
  } status_t;

endpackage

FILE: design/pcx_rle_ctrl.sv
// Controller state machine of the PCX run-length palette decoder.
module pcx_rle_ctrl
  import pcx_rle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_req_type,
  output logic        in_ready,
  input  status_t     st,
  output cmd_t        cmd
);

  `include "pcx_rle_palette_decoder_top_assert.svh"

  state_t state_r, state_nxt;
  logic   accept;

  always_comb begin
    in_ready = (state_r == S_IDLE) ||
               ((state_r == S_EMIT) && st.load_ok && st.last_pix);
    accept   = in_valid && in_ready;
    cmd      = '0;
    cmd.emit = (state_r == S_EMIT) && st.load_ok;

    state_nxt = state_r;
    case (state_r)
      S_IDLE: state_nxt = S_IDLE;
      S_EMIT: begin
        if (cmd.emit && st.last_pix) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (accept) begin
      if (in_req_type == REQ_PALETTE) begin
        cmd.pal_wr = 1'b1;
      end else if (st.pend) begin
        cmd.start     = 1'b1;
        cmd.start_run = 1'b1;
        if (!st.pend_zero) begin
          state_nxt = S_EMIT;
        end
      end else if (st.hdr) begin
        cmd.set_pend = 1'b1;
      end else begin
        cmd.start = 1'b1;
        state_nxt = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PCX_ASSERT_NEXT(a_literal_emits,
    accept && (in_req_type == REQ_DATA) && !st.pend && !st.hdr, state_r == S_EMIT)
  `PCX_ASSERT_NEXT(a_stall_holds, (state_r == S_EMIT) && !st.load_ok, state_r == S_EMIT)
  `PCX_ASSERT_NOW(a_ready_on_last, in_ready && (state_r == S_EMIT), st.last_pix && st.load_ok)

endmodule

FILE: design/pcx_rle_dp.sv
// Datapath of the PCX run-length palette decoder: palette, counters and output register.
module pcx_rle_dp
  import pcx_rle_pkg::*;
#(
  parameter int MAX_WIDTH = 512
)(
  input  logic                             clk,
  input  logic                             rst_n,
  input  cmd_t                             cmd,
  output status_t                          st,
  input  logic [7:0]                       in_code_byte,
  input  logic [7:0]                       in_entry_index,
  input  logic [7:0]                       in_entry_red,
  input  logic [7:0]                       in_entry_green,
  input  logic [7:0]                       in_entry_blue,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   eff_width,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic [8:0]                       out_column,
  output logic                             out_end_of_line,
  output logic                             out_last_of_run
);

  `include "pcx_rle_palette_decoder_top_assert.svh"

  localparam int CNT_W = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = (CNT_W + 1 > WW) ? CNT_W + 1 : WW;
  localparam int XW    = (CNT_W > 9) ? CNT_W : 9;

  logic [RGB_W-1:0] pal_mem [PAL_ENTRIES];
  logic [RGB_W-1:0] rd_data_r;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [RUN_W-1:0] rem_r, rem_nxt;
  logic [RUN_W-1:0] pcnt_r, pcnt_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [RGB_W-1:0] out_rgb_r;
  logic [8:0]       out_col_r;
  logic             out_eol_r;
  logic             out_last_r;

  logic             eol;
  logic [XW-1:0]    col_x;
  logic [7:0]       run_len;

  assign eol     = (CW'(col_r) + CW'(1)) >= CW'(eff_width);
  assign col_x   = XW'(col_r);
  assign run_len = in_code_byte & RUN_LEN_MASK;

  always_comb begin
    st.hdr       = (in_code_byte & RUN_MARK) == RUN_MARK;
    st.pend      = pend_r;
    st.pend_zero = (pcnt_r == '0);
    st.last_pix  = (rem_r == RUN_W'(1)) || eol;
    st.load_ok   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.pal_wr) begin
      pal_mem[in_entry_index] <= {in_entry_red, in_entry_green, in_entry_blue};
    end
    if (cmd.start) begin
      rd_data_r <= pal_mem[in_code_byte];
    end
  end

  always_comb begin
    col_nxt       = col_r;
    rem_nxt       = rem_r;
    pcnt_nxt      = pcnt_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      rem_nxt       = rem_r - RUN_W'(1);
      col_nxt       = eol ? '0 : col_r + CNT_W'(1);
    end
    if (cmd.set_pend) begin
      pend_nxt = 1'b1;
      pcnt_nxt = run_len[RUN_W-1:0];
    end
    if (cmd.start) begin
      if (cmd.start_run) begin
        rem_nxt  = pcnt_r;
        pend_nxt = 1'b0;
        pcnt_nxt = '0;
      end else begin
        rem_nxt = RUN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      rem_r       <= '0;
      pcnt_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      rem_r       <= rem_nxt;
      pcnt_r      <= pcnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rgb_r  <= rd_data_r;
      out_col_r  <= col_x[8:0];
      out_eol_r  <= eol;
      out_last_r <= (rem_r == RUN_W'(1)) || eol;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red         = out_rgb_r[23:16];
  assign out_green       = out_rgb_r[15:8];
  assign out_blue        = out_rgb_r[7:0];
  assign out_column      = out_col_r;
  assign out_end_of_line = out_eol_r;
  assign out_last_of_run = out_last_r;

  `PCX_ASSERT_NEXT(a_eol_wraps, cmd.emit && eol, col_r == '0)
  `PCX_ASSERT_NEXT(a_header_pends, cmd.set_pend, pend_r)
  `PCX_ASSERT_NOW(a_no_pend_while_emit, cmd.emit, !pend_r)

endmodule

FILE: design/pcx_rle_palette_decoder_top.sv
// Top level of the PCX run-length palette decoder with its configuration port.
// Palette writes and run headers are accepted without leaving the idle state. A literal byte's
// color is read from the palette into a read register and then loaded into the output register;
// literal bytes stream at one per cycle while out_ready does not stall. After the color byte of
// a run of n pixels the input is held until the last pixel of the run or of the line is loaded,
// at one pixel per cycle while out_ready does not stall. A stall on out_ready holds the pixel
// and, while a pixel waits to be loaded, the input. Pixels are delivered in order with their line
// column; reading a palette entry that was never written returns an undefined color.
module pcx_rle_palette_decoder_top
  import pcx_rle_pkg::*;
#(
  parameter int MAX_WIDTH = 512
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_code_byte,
  input  logic [7:0]  in_entry_index,
  input  logic [7:0]  in_entry_red,
  input  logic [7:0]  in_entry_green,
  input  logic [7:0]  in_entry_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [8:0]  out_column,
  output logic        out_end_of_line,
  output logic        out_last_of_run,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > LW_W) ? WW : LW_W;

  logic [LW_W-1:0] lw_r;
  logic [WW-1:0]   eff_width;
  logic            reg_sel;
  cmd_t            cmd;
  status_t         st;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[2] == 1'(REG_LINE_WIDTH);
  assign cfg_prdata = reg_sel ? 32'(lw_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r <= LW_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      lw_r <= cfg_pwdata[LW_W-1:0];
    end
  end

  always_comb begin
    if (lw_r == '0) begin
      eff_width = WW'(1);
    end else if (CW'(lw_r) > CW'(MAX_WIDTH)) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(lw_r);
    end
  end

  pcx_rle_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .st          (st),
    .cmd         (cmd)
  );

  pcx_rle_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_code_byte    (in_code_byte),
    .in_entry_index  (in_entry_index),
    .in_entry_red    (in_entry_red),
    .in_entry_green  (in_entry_green),
    .in_entry_blue   (in_entry_blue),
    .eff_width       (eff_width),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_column      (out_column),
    .out_end_of_line (out_end_of_line),
    .out_last_of_run (out_last_of_run)
  );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the PCX run-length palette decoder with random handshake pressure.
module testbench;
  import pcx_rle_pkg::*;

  localparam int MAX_LINE         = 512;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int RANDOM_PER_PHASE = 36;

  typedef struct {
    logic       req_type;
    logic [7:0] code_byte;
    logic [7:0] entry_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
  } pcx_request_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] column;
    logic       end_of_line;
    logic       last_of_run;
  } pcx_pixel_t;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_THIRD, READY_MOSTLY} ready_mode_t;

  class pcx_pixel_predictor;
    logic [23:0]   palette [256];
    bit            run_armed;
    logic [5:0]    run_length;
    logic [8:0]    column;
    logic [9:0]    line_width;
    pcx_pixel_t    expected_pixels [$];
    int            error_count;

    function new();
      run_armed   = 1'b0;
      run_length  = '0;
      column      = '0;
      line_width  = LW_RESET;
      error_count = 0;
    endfunction

    function void note_request(pcx_request_t rq);
      pcx_pixel_t  pix;
      logic [23:0] rgb;
      int          count;
      int          width;
      if (rq.req_type == REQ_PALETTE) begin
        palette[rq.entry_index] = {rq.entry_red, rq.entry_green, rq.entry_blue};
        return;
      end
      if (run_armed) begin
        count      = run_length;
        run_armed  = 1'b0;
        run_length = '0;
      end else if ((rq.code_byte & RUN_MARK) == RUN_MARK) begin
        run_armed  = 1'b1;
        run_length = 6'(rq.code_byte & RUN_LEN_MASK);
        return;
      end else begin
        count = 1;
      end
      width = (line_width == 0) ? 1 : (line_width > MAX_LINE) ? MAX_LINE : int'(line_width);
      rgb   = palette[rq.code_byte];
      for (int i = 0; i < count; i++) begin
        pix.red         = rgb[23:16];
        pix.green       = rgb[15:8];
        pix.blue        = rgb[7:0];
        pix.column      = column;
        pix.end_of_line = (int'(column) + 1 >= width);
        pix.last_of_run = pix.end_of_line || (i == count - 1);
        expected_pixels.push_back(pix);
        if (pix.end_of_line) begin
          column = '0;
          break;
        end
        column++;
      end
    endfunction

    function void check_field(string name, logic [31:0] expv, logic [31:0] actual);
      if (expv !== actual) begin
        $error("%s mismatch: expected %0d, actual %0d", name, expv, actual);
        error_count++;
      end
    endfunction

    function void check_pixel(pcx_pixel_t got);
      pcx_pixel_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel transaction at column %0d", got.column);
        error_count++;
        return;
      end
      want = expected_pixels.pop_front();
      check_field("red", 32'(want.red), 32'(got.red));
      check_field("green", 32'(want.green), 32'(got.green));
      check_field("blue", 32'(want.blue), 32'(got.blue));
      check_field("column", 32'(want.column), 32'(got.column));
      check_field("end_of_line", 32'(want.end_of_line), 32'(got.end_of_line));
      check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    endfunction
  endclass

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic        in_req_type    = 1'b0;
  logic [7:0]  in_code_byte   = '0;
  logic [7:0]  in_entry_index = '0;
  logic [7:0]  in_entry_red   = '0;
  logic [7:0]  in_entry_green = '0;
  logic [7:0]  in_entry_blue  = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [8:0]  out_column;
  logic        out_end_of_line;
  logic        out_last_of_run;
  logic        cfg_psel       = 1'b0;
  logic        cfg_penable    = 1'b0;
  logic        cfg_pwrite     = 1'b0;
  logic [2:0]  cfg_paddr      = '0;
  logic [31:0] cfg_pwdata     = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pcx_pixel_predictor decoder_model;
  int                 burst_left = 0;
  int                 items_sent = 0;
  bit                 palette_written [256];
  logic [7:0]         written_indexes [$];
  int                 ready_tick = 0;
  ready_mode_t        ready_mode = READY_ALWAYS;

  pcx_rle_palette_decoder_top #(.MAX_WIDTH(MAX_LINE)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_code_byte    (in_code_byte),
    .in_entry_index  (in_entry_index),
    .in_entry_red    (in_entry_red),
    .in_entry_green  (in_entry_green),
    .in_entry_blue   (in_entry_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_column      (out_column),
    .out_end_of_line (out_end_of_line),
    .out_last_of_run (out_last_of_run),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin : ready_pattern
    ready_tick++;
    if (ready_tick % 97 == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
    end
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_COIN: out_ready <= 1'($urandom_range(0, 1));
      READY_THIRD: out_ready <= (ready_tick % 3 != 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin : transaction_monitor
    pcx_request_t rq;
    pcx_pixel_t   px;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        px.red         = out_red;
        px.green       = out_green;
        px.blue        = out_blue;
        px.column      = out_column;
        px.end_of_line = out_end_of_line;
        px.last_of_run = out_last_of_run;
        decoder_model.check_pixel(px);
      end
      if (in_valid && in_ready) begin
        rq.req_type    = in_req_type;
        rq.code_byte   = in_code_byte;
        rq.entry_index = in_entry_index;
        rq.entry_red   = in_entry_red;
        rq.entry_green = in_entry_green;
        rq.entry_blue  = in_entry_blue;
        decoder_model.note_request(rq);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("testbench failed");
    $finish;
  end

  task automatic drive_request(input pcx_request_t rq);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid       <= 1'b1;
    in_req_type    <= rq.req_type;
    in_code_byte   <= rq.code_byte;
    in_entry_index <= rq.entry_index;
    in_entry_red   <= rq.entry_red;
    in_entry_green <= rq.entry_green;
    in_entry_blue  <= rq.entry_blue;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic write_palette(input logic [7:0] index, input logic [23:0] rgb);
    pcx_request_t rq;
    rq.req_type    = REQ_PALETTE;
    rq.code_byte   = 8'($urandom);
    rq.entry_index = index;
    {rq.entry_red, rq.entry_green, rq.entry_blue} = rgb;
    drive_request(rq);
    if (!palette_written[index]) begin
      palette_written[index] = 1'b1;
      written_indexes.push_back(index);
    end
  endtask

  task automatic send_data(input logic [7:0] code);
    pcx_request_t rq;
    rq.req_type    = REQ_DATA;
    rq.code_byte   = code;
    rq.entry_index = 8'($urandom);
    rq.entry_red   = 8'($urandom);
    rq.entry_green = 8'($urandom);
    rq.entry_blue  = 8'($urandom);
    drive_request(rq);
  endtask

  task automatic send_run(input logic [5:0] run_len, input logic [7:0] index);
    send_data(RUN_MARK | 8'(run_len));
    send_data(index);
  endtask

  function automatic logic [7:0] pick_color(input int lo, input int hi);
    logic [7:0] idx;
    do begin
      idx = written_indexes[$urandom_range(0, written_indexes.size() - 1)];
    end while (idx < lo || idx > hi);
    return idx;
  endfunction

  function automatic logic [5:0] pick_run_length();
    if ($urandom_range(0, 7) == 0) begin
      return ($urandom_range(0, 1) == 0) ? 6'd0 : 6'd63;
    end
    return 6'($urandom_range(1, 20));
  endfunction

  task automatic wait_until_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (decoder_model.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_line_width(input logic [9:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(REG_LINE_WIDTH * 4);
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    decoder_model.line_width = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[9:0] !== value) begin
      $error("line_width readback mismatch: expected %0d, actual %0d", value, cfg_prdata[9:0]);
      decoder_model.error_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_step();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      write_palette(8'($urandom), 24'($urandom));
    end else if (pick < 55) begin
      send_data(pick_color(0, 8'hBF));
    end else if (pick < 88) begin
      send_run(pick_run_length(), pick_color(0, 8'hFF));
    end else if (pick < 94) begin
      send_data(RUN_MARK | 8'(pick_run_length()));
      write_palette(8'($urandom), 24'($urandom));
      send_data(pick_color(0, 8'hFF));
    end else begin
      send_run(pick_run_length(), pick_color(8'hC0, 8'hFF));
    end
  endtask

  initial begin : stimulus
    logic [9:0] phase_widths [8];
    int         phase_goal;
    decoder_model = new();
    phase_widths  = '{10'd8, 10'd1, 10'd0, 10'd512, 10'd1023, 10'd3, 10'd320, 10'd0};
    phase_widths[7] = 10'($urandom_range(2, 511));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    write_palette(8'h00, 24'h000000);
    write_palette(8'hFF, 24'hFFFFFF);
    write_palette(8'h3F, 24'($urandom));
    write_palette(8'hBF, 24'($urandom));
    write_palette(8'hC0, 24'($urandom));
    write_palette(8'h80, 24'hA55AC3);
    send_data(8'h00);
    send_data(8'hBF);
    send_data(8'h80);
    send_run(6'd63, 8'hFF);
    send_run(6'd0, 8'h3F);
    send_data(RUN_MARK | 8'd5);
    write_palette(8'h10, 24'h123456);
    send_data(8'h10);
    send_run(6'd2, 8'hC0);
    wait_until_drained();

    for (int p = 0; p < 8; p++) begin
      program_line_width(phase_widths[p]);
      phase_goal = items_sent + RANDOM_PER_PHASE;
      while (items_sent < phase_goal) random_step();
      wait_until_drained();
    end

    if (decoder_model.error_count == 0 && decoder_model.expected_pixels.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
